FILE: rtl/mrrc_pkg.sv
// Package: types, codes and CRC helper for the Modbus RTU reply checker.
`default_nettype none

package mrrc_pkg;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] CFG_FUNC_CODE = 2'd1;
  localparam logic [1:0] CFG_FIRST_TO  = 2'd2;
  localparam logic [1:0] CFG_GAP_TO    = 2'd3;

  localparam logic [7:0]  DEV_ADDR_RST  = 8'd1;
  localparam logic [7:0]  FUNC_CODE_RST = 8'd4;
  localparam logic [15:0] FIRST_TO_RST  = 16'd200;
  localparam logic [15:0] GAP_TO_RST    = 16'd30;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [3:0] FLOAT_LEN  = 4'd9;
  localparam logic [3:0] WORD_LEN   = 4'd7;
  localparam int         FRAME_MAX  = 9;
  localparam logic [7:0] FLOAT_BCNT = 8'd4;
  localparam logic [7:0] WORD_BCNT  = 8'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FIRST = 3'd1,
    ST_SHORT    = 3'd2,
    ST_CRC_ERR  = 3'd3,
    ST_BAD_HDR  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_RECV = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       reply_kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] reply_value;
    logic        value_is_word;
  } out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/modbus_rtu_response_checker_unit.sv
// Top level: Modbus RTU read-input-registers reply checker with CRC-16.
//
// Input channel (in_valid/in_ready/in_data) carries one transaction per
// start, received byte or millisecond tick. A start arms the block for a
// 9-byte float reply or a 7-byte integer reply; bytes update a running
// CRC-16 and fill a 9-entry frame store; ticks run the first-byte and
// inter-byte timeouts. Bytes and ticks while idle are dropped.
// Output channel (out_valid/out_ready/out_data) carries one status and value
// per finished frame or timeout.
// A result is registered into the output register, or into the skid entry
// while the receiver stalls. Throughput: one input transaction per cycle
// while in_ready is high; the byte-wide CRC update is a single unrolled stage.
// The config port (cfg_we/cfg_index/cfg_wdata) writes one register per cycle.
// Reset returns config registers to defaults, phase to idle, output empty.
// When the receiver stalls, one further result lands in a skid entry and
// in_ready drops until the output drains.
`default_nettype none

module modbus_rtu_response_checker_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  mrrc_pkg::in_t      in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output mrrc_pkg::out_t     out_data,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [15:0]        cfg_wdata
);

  logic [7:0]  dev_addr_r;
  logic [7:0]  func_code_r;
  logic [15:0] first_to_r;
  logic [15:0] gap_to_r;

  mrrc_pkg::phase_t phase_r, phase_nxt;
  logic             kind_r, kind_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic [7:0]       frame_r [mrrc_pkg::FRAME_MAX];

  logic           in_fire;
  logic           frame_we;
  logic           res_push;
  logic           res_ready;
  mrrc_pkg::out_t res_data;
  logic [3:0]     frame_len;
  logic [3:0]     cnt_inc;
  logic [16:0]    timer_inc;
  logic [15:0]    crc_got;
  logic           crc_ok;
  logic           hdr_ok;
  logic [31:0]    value;

  assign in_ready = res_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= mrrc_pkg::DEV_ADDR_RST;
      func_code_r <= mrrc_pkg::FUNC_CODE_RST;
      first_to_r  <= mrrc_pkg::FIRST_TO_RST;
      gap_to_r    <= mrrc_pkg::GAP_TO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrrc_pkg::CFG_DEV_ADDR:  dev_addr_r  <= cfg_wdata[7:0];
        mrrc_pkg::CFG_FUNC_CODE: func_code_r <= cfg_wdata[7:0];
        mrrc_pkg::CFG_FIRST_TO:  first_to_r  <= cfg_wdata;
        mrrc_pkg::CFG_GAP_TO:    gap_to_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame check when the incoming byte is the last one
  assign crc_got = kind_r ? {in_data.rx_byte, frame_r[5]} : {in_data.rx_byte, frame_r[7]};
  assign crc_ok  = (crc_got == crc_r);
  assign hdr_ok  = (frame_r[0] == dev_addr_r) && (frame_r[1] == func_code_r) &&
                   (frame_r[2] == (kind_r ? mrrc_pkg::WORD_BCNT : mrrc_pkg::FLOAT_BCNT));
  assign value   = kind_r ? {16'd0, frame_r[3], frame_r[4]}
                          : {frame_r[6], frame_r[5], frame_r[4], frame_r[3]};

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    timer_nxt = timer_r;
    frame_we  = 1'b0;
    res_push  = 1'b0;
    res_data.status        = mrrc_pkg::ST_OK;
    res_data.reply_value   = 32'd0;
    res_data.value_is_word = kind_r;
    frame_len = kind_r ? mrrc_pkg::WORD_LEN : mrrc_pkg::FLOAT_LEN;
    cnt_inc   = cnt_r + 4'd1;
    timer_inc = {1'b0, timer_r} + 17'd1;
    if (in_fire) begin
      unique case (in_data.mode)
        mrrc_pkg::MODE_START: begin
          phase_nxt = mrrc_pkg::PH_WAIT;
          kind_nxt  = in_data.reply_kind;
          cnt_nxt   = 4'd0;
          crc_nxt   = mrrc_pkg::CRC_INIT;
          timer_nxt = 16'd0;
        end
        mrrc_pkg::MODE_BYTE: begin
          if (phase_r != mrrc_pkg::PH_IDLE && cnt_r < frame_len) begin
            frame_we  = 1'b1;
            if (cnt_r < frame_len - 4'd2) begin
              crc_nxt = mrrc_pkg::crc_byte(crc_r, in_data.rx_byte);
            end
            cnt_nxt   = cnt_inc;
            timer_nxt = 16'd0;
            phase_nxt = mrrc_pkg::PH_RECV;
            if (cnt_inc == frame_len) begin
              res_push  = 1'b1;
              phase_nxt = mrrc_pkg::PH_IDLE;
              priority if (!crc_ok) begin
                res_data.status = mrrc_pkg::ST_CRC_ERR;
              end else if (!hdr_ok) begin
                res_data.status = mrrc_pkg::ST_BAD_HDR;
              end else begin
                res_data.reply_value = value;
              end
            end
          end
        end
        mrrc_pkg::MODE_TICK: begin
          if (phase_r == mrrc_pkg::PH_WAIT) begin
            if (timer_inc >= {1'b0, first_to_r}) begin
              res_push        = 1'b1;
              res_data.status = mrrc_pkg::ST_NO_FIRST;
              phase_nxt       = mrrc_pkg::PH_IDLE;
            end else begin
              timer_nxt = timer_inc[15:0];
            end
          end else if (phase_r == mrrc_pkg::PH_RECV) begin
            if (timer_r >= gap_to_r) begin
              res_push        = 1'b1;
              res_data.status = mrrc_pkg::ST_SHORT;
              phase_nxt       = mrrc_pkg::PH_IDLE;
            end else begin
              timer_nxt = timer_inc[15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mrrc_pkg::PH_IDLE;
      kind_r  <= 1'b0;
      cnt_r   <= 4'd0;
      crc_r   <= mrrc_pkg::CRC_INIT;
      timer_r <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_r[cnt_r] <= in_data.rx_byte;
    end
  end

  mrrc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_push),
    .push_data  (res_data),
    .push_ready (res_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> phase_r == mrrc_pkg::PH_IDLE)
    else $error("phase not idle after result");

  a_wait_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mrrc_pkg::PH_WAIT |-> cnt_r == 4'd0)
    else $error("byte count nonzero while waiting for first byte");

  a_recv_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == mrrc_pkg::PH_RECV |-> (cnt_r != 4'd0) && (cnt_r < frame_len))
    else $error("byte count out of range while receiving");

endmodule

`default_nettype wire

FILE: rtl/mrrc_out_buf.sv
// Output register with one skid entry for result transactions.
`default_nettype none

module mrrc_out_buf (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push_valid,
  input  mrrc_pkg::out_t     push_data,
  output logic               push_ready,
  output logic               out_valid,
  input  wire                out_ready,
  output mrrc_pkg::out_t     out_data
);

  logic           main_v_r;
  logic           skid_v_r;
  mrrc_pkg::out_t main_r;
  mrrc_pkg::out_t skid_r;

  assign push_ready = !skid_v_r;
  assign out_valid  = main_v_r;
  assign out_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push_valid;
      end
    end else if (push_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (push_valid) begin
        main_r <= push_data;
      end
    end else if (push_valid) begin
      skid_r <= push_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held with empty output register");

endmodule

`default_nettype wire
